// ----- hdl/glyph_alpha_blend_yuv_top_assert.svh -----
// Assertion macros for the glyph overlay blender.
// Both forms sample on clk and are disabled while rst_n is low.
`ifndef GLYPH_ALPHA_BLEND_YUV_TOP_ASSERT_SVH
`define GLYPH_ALPHA_BLEND_YUV_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define GAB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("overlay blender check failed");
// antecedent implies consequent in the next cycle
`define GAB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("overlay blender check failed");
`else
`define GAB_ASSERT_IMP(lbl, ante, cons)
`define GAB_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- hdl/gab_pkg.sv -----
// Shared types and constants for the glyph overlay blender.
// No dependencies.
package gab_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_OVERLAY_COLOR  = 3'd0;
    localparam logic [2:0] REG_FRAME_WIDTH    = 3'd1;
    localparam logic [2:0] REG_FRAME_HEIGHT   = 3'd2;
    localparam logic [2:0] REG_CHROMA_SHIFT_X = 3'd3;
    localparam logic [2:0] REG_CHROMA_SHIFT_Y = 3'd4;

    localparam int CFG_IDX_W = 3;
    localparam int DIM_W     = 13;
    localparam int POS_W     = 12;
    localparam int SHIFT_W   = 2;

    localparam logic [12:0] FRAME_WIDTH_RST  = 13'd1920;
    localparam logic [12:0] FRAME_HEIGHT_RST = 13'd1080;
    localparam logic [1:0]  CHROMA_SHIFT_RST = 2'd1;

    // colour conversion weights, magnitudes only: signs are applied in the sums
    localparam int PROD_W = 18;
    localparam int SUM_W  = 20;
    localparam logic [9:0] COEF_RY  = 10'd263;
    localparam logic [9:0] COEF_GY  = 10'd516;
    localparam logic [9:0] COEF_BY  = 10'd100;
    localparam logic [9:0] COEF_RCB = 10'd152;
    localparam logic [9:0] COEF_GCB = 10'd298;
    localparam logic [9:0] COEF_BCB = 10'd450;
    localparam logic [9:0] COEF_RCR = 10'd450;
    localparam logic [9:0] COEF_GCR = 10'd376;
    localparam logic [9:0] COEF_BCR = 10'd73;
    localparam logic [7:0] OFS_Y    = 8'd16;
    localparam logic [7:0] OFS_C    = 8'd128;
    localparam logic [7:0] FULL     = 8'd255;

    // per-stage load enables of the pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } gab_adv_t;

endpackage

// ----- hdl/gab_csc.sv -----
// Two-stage RGB to limited-range YCbCr conversion of the overlay colour.
// Depends on gab_pkg; runs in step with the blender pipeline.
module gab_csc (
    input  logic                clk,
    input  gab_pkg::gab_adv_t   adv,
    input  logic [31:0]         overlay_color,
    output logic [7:0]          cy,
    output logic [7:0]          cu,
    output logic [7:0]          cv
);
    import gab_pkg::*;

    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;

    logic [PROD_W-1:0] p_ry_reg, p_gy_reg, p_by_reg;
    logic [PROD_W-1:0] p_rcb_reg, p_gcb_reg, p_bcb_reg;
    logic [PROD_W-1:0] p_rcr_reg, p_gcr_reg, p_bcr_reg;

    logic signed [SUM_W-1:0] y_sum;
    logic signed [SUM_W-1:0] cb_sum;
    logic signed [SUM_W-1:0] cr_sum;

    logic [7:0] cy_reg, cu_reg, cv_reg;

    assign r = overlay_color[31:24];
    assign g = overlay_color[23:16];
    assign b = overlay_color[15:8];

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            p_ry_reg  <= PROD_W'(r) * PROD_W'(COEF_RY);
            p_gy_reg  <= PROD_W'(g) * PROD_W'(COEF_GY);
            p_by_reg  <= PROD_W'(b) * PROD_W'(COEF_BY);
            p_rcb_reg <= PROD_W'(r) * PROD_W'(COEF_RCB);
            p_gcb_reg <= PROD_W'(g) * PROD_W'(COEF_GCB);
            p_bcb_reg <= PROD_W'(b) * PROD_W'(COEF_BCB);
            p_rcr_reg <= PROD_W'(r) * PROD_W'(COEF_RCR);
            p_gcr_reg <= PROD_W'(g) * PROD_W'(COEF_GCR);
            p_bcr_reg <= PROD_W'(b) * PROD_W'(COEF_BCR);
        end
    end

    always_comb
    begin
        y_sum  = $signed({2'b00, p_ry_reg}) + $signed({2'b00, p_gy_reg})
               + $signed({2'b00, p_by_reg});
        cb_sum = $signed({2'b00, p_bcb_reg}) - $signed({2'b00, p_rcb_reg})
               - $signed({2'b00, p_gcb_reg});
        cr_sum = $signed({2'b00, p_rcr_reg}) - $signed({2'b00, p_gcr_reg})
               - $signed({2'b00, p_bcr_reg});
    end

    // bits 17:10 of the two's complement sum are the low byte of floor(sum/1024)
    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            cy_reg <= y_sum[17:10] + OFS_Y;
            cu_reg <= cb_sum[17:10] + OFS_C;
            cv_reg <= cr_sum[17:10] + OFS_C;
        end
    end

    assign cy = cy_reg;
    assign cu = cu_reg;
    assign cv = cv_reg;

endmodule

// ----- hdl/glyph_alpha_blend_yuv_top.sv -----
// Glyph overlay blender: four register stages, one pixel word per clock.
// Each accepted word passes through stages 1, 2, 3 and 4 in turn; m_tvalid is the stage 4 valid.
// Throughput: one word per cycle; the pipeline stalls only when m_tready is low.
// Reset (rst_n low, asynchronous) empties the pipeline and loads register defaults:
// colour 0, frame 1920 x 1080, both chroma shifts 1.
// Depends on gab_pkg, gab_csc and glyph_alpha_blend_yuv_top_assert.svh.
`include "glyph_alpha_blend_yuv_top_assert.svh"

module glyph_alpha_blend_yuv_top (
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [gab_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]               cfg_data,
    // input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // coverage[7:0], pixel_x[19:8], pixel_y[31:20], old_luma[39:32],
    // old_cb[47:40], old_cr[55:48]
    input  logic [55:0]               s_tdata,
    // output stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // new_luma[7:0], new_cb[15:8], new_cr[23:16], chroma_col[35:24],
    // chroma_row[47:36], zero[55:48]
    output logic [55:0]               m_tdata,
    // write_enable[0]
    output logic [0:0]                m_tuser
);
    import gab_pkg::*;

    // configuration
    logic [31:0]        overlay_color_reg;
    logic [DIM_W-1:0]   frame_width_reg;
    logic [DIM_W-1:0]   frame_height_reg;
    logic [SHIFT_W-1:0] chroma_shift_x_reg;
    logic [SHIFT_W-1:0] chroma_shift_y_reg;

    // input fields
    logic [7:0]       in_cov;
    logic [POS_W-1:0] in_x;
    logic [POS_W-1:0] in_y;
    logic [7:0]       in_oy;
    logic [7:0]       in_ocb;
    logic [7:0]       in_ocr;

    // pipeline control
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    gab_adv_t adv;

    // stage 1
    logic [15:0]      kprod_reg;
    logic [7:0]       oy1_reg, ocb1_reg, ocr1_reg;
    logic             in1_reg;
    logic [POS_W-1:0] col1_reg, row1_reg;
    // stage 2
    logic [7:0]       k2_reg;
    logic [7:0]       oy2_reg, ocb2_reg, ocr2_reg;
    logic             in2_reg;
    logic [POS_W-1:0] col2_reg, row2_reg;
    // stage 3
    logic [15:0]      my_k_reg, mcb_k_reg, mcr_k_reg;
    logic [15:0]      my_o_reg, mcb_o_reg, mcr_o_reg;
    logic             in3_reg;
    logic [POS_W-1:0] col3_reg, row3_reg;
    // stage 4 (output)
    logic [7:0]       luma4_reg, cb4_reg, cr4_reg;
    logic             in4_reg;
    logic [POS_W-1:0] col4_reg, row4_reg;

    logic [7:0]  cy, cu, cv;
    logic [7:0]  opacity;
    logic [7:0]  inv_k;
    logic        in_frame;
    logic [16:0] sum_y, sum_cb, sum_cr;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overlay_color_reg  <= '0;
            frame_width_reg    <= FRAME_WIDTH_RST;
            frame_height_reg   <= FRAME_HEIGHT_RST;
            chroma_shift_x_reg <= CHROMA_SHIFT_RST;
            chroma_shift_y_reg <= CHROMA_SHIFT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_OVERLAY_COLOR:  overlay_color_reg  <= cfg_data;
                REG_FRAME_WIDTH:    frame_width_reg    <= cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT:   frame_height_reg   <= cfg_data[DIM_W-1:0];
                REG_CHROMA_SHIFT_X: chroma_shift_x_reg <= cfg_data[SHIFT_W-1:0];
                REG_CHROMA_SHIFT_Y: chroma_shift_y_reg <= cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_cov = s_tdata[7:0];
    assign in_x   = s_tdata[19:8];
    assign in_y   = s_tdata[31:20];
    assign in_oy  = s_tdata[39:32];
    assign in_ocb = s_tdata[47:40];
    assign in_ocr = s_tdata[55:48];

    // a stage loads when it is empty or the stage after it moves on
    always_comb
    begin
        adv.s4 = !v4_reg || m_tready;
        adv.s3 = !v3_reg || adv.s4;
        adv.s2 = !v2_reg || adv.s3;
        adv.s1 = !v1_reg || adv.s2;
        v1_next = adv.s1 ? s_tvalid : v1_reg;
        v2_next = adv.s2 ? v1_reg   : v2_reg;
        v3_next = adv.s3 ? v2_reg   : v3_reg;
        v4_next = adv.s4 ? v3_reg   : v4_reg;
    end

    assign s_tready = adv.s1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    gab_csc u_csc (
        .clk           (clk),
        .adv           (adv),
        .overlay_color (overlay_color_reg),
        .cy            (cy),
        .cu            (cu),
        .cv            (cv)
    );

    assign opacity  = FULL - overlay_color_reg[7:0];
    assign in_frame = ({1'b0, in_x} < frame_width_reg) && ({1'b0, in_y} < frame_height_reg);

    // stage 1: coverage weight product, clip test, chroma position
    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            kprod_reg <= {8'b0, in_cov} * {8'b0, opacity};
            oy1_reg   <= in_oy;
            ocb1_reg  <= in_ocb;
            ocr1_reg  <= in_ocr;
            in1_reg   <= in_frame;
            col1_reg  <= in_x >> chroma_shift_x_reg;
            row1_reg  <= in_y >> chroma_shift_y_reg;
        end
    end

    // stage 2: weight k
    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            k2_reg   <= kprod_reg[15:8];
            oy2_reg  <= oy1_reg;
            ocb2_reg <= ocb1_reg;
            ocr2_reg <= ocr1_reg;
            in2_reg  <= in1_reg;
            col2_reg <= col1_reg;
            row2_reg <= row1_reg;
        end
    end

    assign inv_k = FULL - k2_reg;

    // stage 3: blend products
    always_ff @(posedge clk)
    begin
        if (adv.s3)
        begin
            my_k_reg  <= {8'b0, k2_reg} * {8'b0, cy};
            mcb_k_reg <= {8'b0, k2_reg} * {8'b0, cu};
            mcr_k_reg <= {8'b0, k2_reg} * {8'b0, cv};
            my_o_reg  <= {8'b0, inv_k} * {8'b0, oy2_reg};
            mcb_o_reg <= {8'b0, inv_k} * {8'b0, ocb2_reg};
            mcr_o_reg <= {8'b0, inv_k} * {8'b0, ocr2_reg};
            in3_reg   <= in2_reg;
            col3_reg  <= col2_reg;
            row3_reg  <= row2_reg;
        end
    end

    assign sum_y  = {1'b0, my_k_reg}  + {1'b0, my_o_reg};
    assign sum_cb = {1'b0, mcb_k_reg} + {1'b0, mcb_o_reg};
    assign sum_cr = {1'b0, mcr_k_reg} + {1'b0, mcr_o_reg};

    // stage 4: sum, scale, zero the samples outside the frame
    always_ff @(posedge clk)
    begin
        if (adv.s4)
        begin
            luma4_reg <= in3_reg ? sum_y[15:8]  : 8'd0;
            cb4_reg   <= in3_reg ? sum_cb[15:8] : 8'd0;
            cr4_reg   <= in3_reg ? sum_cr[15:8] : 8'd0;
            in4_reg   <= in3_reg;
            col4_reg  <= col3_reg;
            row4_reg  <= row3_reg;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {8'b0, row4_reg, col4_reg, cr4_reg, cb4_reg, luma4_reg};
    assign m_tuser  = in4_reg;

    `GAB_ASSERT_IMP(a_clip_zero, m_tvalid && !m_tuser[0], m_tdata[23:0] == 24'd0)
    `GAB_ASSERT_IMP(a_stall_source, !s_tready, m_tvalid && !m_tready)
    `GAB_ASSERT_NXT(a_s1_moves, v1_reg && adv.s2, v2_reg)
    `GAB_ASSERT_NXT(a_out_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

// ----- verif/tb.sv -----
// Self-checking bench for glyph_alpha_blend_yuv_top: random and directed pixel words,
// config rewrites between phases, scoreboard against an in-bench blend predictor.
// Depends on gab_pkg and the RTL under hdl/.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gab_pkg::*;

    // not a register: writes here must leave every setting alone
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

    typedef struct packed {
        logic [7:0]  old_cr;
        logic [7:0]  old_cb;
        logic [7:0]  old_luma;
        logic [11:0] pixel_y;
        logic [11:0] pixel_x;
        logic [7:0]  coverage;
    } pix_word_t;

    typedef struct packed {
        logic [7:0]  pad;
        logic [11:0] chroma_row;
        logic [11:0] chroma_col;
        logic [7:0]  new_cr;
        logic [7:0]  new_cb;
        logic [7:0]  new_luma;
    } blend_word_t;

    typedef struct packed {
        blend_word_t word;
        logic        wr_en;
    } blend_rec_t;

    typedef enum logic [1:0] {SINK_ALWAYS, SINK_RANDOM, SINK_PATTERN} sink_mode_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    pix_word_t            s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [55:0]          m_tdata;
    logic [0:0]           m_tuser;

    // predictor copy of the registers
    logic [31:0]      cfg_color = '0;
    logic [DIM_W-1:0] cfg_width = FRAME_WIDTH_RST;
    logic [DIM_W-1:0] cfg_height = FRAME_HEIGHT_RST;
    logic [1:0]       cfg_shx = CHROMA_SHIFT_RST;
    logic [1:0]       cfg_shy = CHROMA_SHIFT_RST;

    pix_word_t  pixel_q[$];
    blend_rec_t blended_q[$];

    int          mismatch_cnt = 0;
    int          result_no = 0;
    logic        src_fire = 1'b0;
    logic        src_steady = 1'b1;
    int          burst_left = 0;
    int          gap_left = 0;
    sink_mode_t  sink_mode = SINK_ALWAYS;
    logic [7:0]  sink_pat = 8'hFF;
    int          sink_hold_req = 0;
    int          sink_hold = 0;
    blend_rec_t  exp_r;
    blend_word_t got_w;

    glyph_alpha_blend_yuv_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [7:0] blend_sample(int k, int ovl, int old);
        return 8'((k * ovl + (255 - k) * old) >> 8);
    endfunction

    function automatic blend_rec_t blend_overlay(pix_word_t px);
        int         red;
        int         green;
        int         blue;
        int         k;
        logic [7:0] ovl_y;
        logic [7:0] ovl_cb;
        logic [7:0] ovl_cr;
        blend_rec_t res;
        red   = int'(cfg_color[31:24]);
        green = int'(cfg_color[23:16]);
        blue  = int'(cfg_color[15:8]);
        // arithmetic shift floors the negative chroma sums
        ovl_y  = 8'(((263 * red + 516 * green + 100 * blue) >>> 10) + 16);
        ovl_cb = 8'(((-152 * red - 298 * green + 450 * blue) >>> 10) + 128);
        ovl_cr = 8'(((450 * red - 376 * green - 73 * blue) >>> 10) + 128);
        k = (int'(px.coverage) * (255 - int'(cfg_color[7:0]))) >> 8;
        res = '0;
        res.wr_en = (px.pixel_x < cfg_width) && (px.pixel_y < cfg_height);
        if (res.wr_en)
        begin
            res.word.new_luma = blend_sample(k, int'(ovl_y), int'(px.old_luma));
            res.word.new_cb   = blend_sample(k, int'(ovl_cb), int'(px.old_cb));
            res.word.new_cr   = blend_sample(k, int'(ovl_cr), int'(px.old_cr));
        end
        res.word.chroma_col = px.pixel_x >> cfg_shx;
        res.word.chroma_row = px.pixel_y >> cfg_shy;
        return res;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("%0t ns: word %0d, %s mismatch: expected %0d, got %0d",
                         $realtime, result_no, name, want, got);
        end
    endtask

    // input acceptance and output checking
    always @(posedge clk)
    begin
        src_fire = rst_n && s_tvalid && s_tready;
        if (src_fire)
            blended_q.push_back(blend_overlay(s_tdata));
        if (rst_n && m_tvalid && m_tready)
        begin
            result_no++;
            if (blended_q.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("%0t ns: unexpected output word %h", $realtime, m_tdata);
            end
            else
            begin
                exp_r = blended_q.pop_front();
                got_w = m_tdata;
                check_field("new_luma", exp_r.word.new_luma, got_w.new_luma);
                check_field("new_cb", exp_r.word.new_cb, got_w.new_cb);
                check_field("new_cr", exp_r.word.new_cr, got_w.new_cr);
                check_field("chroma_col", exp_r.word.chroma_col, got_w.chroma_col);
                check_field("chroma_row", exp_r.word.chroma_row, got_w.chroma_row);
                check_field("pad", exp_r.word.pad, got_w.pad);
                check_field("write_enable", exp_r.wr_en, m_tuser[0]);
            end
        end
    end

    // sender: bursts of random length, random gaps unless steady
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || src_fire))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pixel_q.size() > 0)
            begin
                s_tdata  <= pixel_q.pop_front();
                s_tvalid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 30);
                    gap_left   = src_steady ? 0 : $urandom_range(1, 6);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: long hold-off on request, otherwise its own stall pattern
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (sink_hold_req > 0)
            begin
                sink_hold     = sink_hold_req;
                sink_hold_req = 0;
            end
            if (sink_hold > 0)
            begin
                sink_hold--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (sink_mode)
                    SINK_RANDOM:  m_tready <= ($urandom_range(0, 9) > 2);
                    SINK_PATTERN:
                    begin
                        m_tready <= sink_pat[0];
                        sink_pat = {sink_pat[0], sink_pat[7:1]};
                    end
                    default:      m_tready <= 1'b1;
                endcase
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_OVERLAY_COLOR:  cfg_color  = data;
            REG_FRAME_WIDTH:    cfg_width  = data[DIM_W-1:0];
            REG_FRAME_HEIGHT:   cfg_height = data[DIM_W-1:0];
            REG_CHROMA_SHIFT_X: cfg_shx    = data[1:0];
            REG_CHROMA_SHIFT_Y: cfg_shy    = data[1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(logic [31:0] color, logic [31:0] width, logic [31:0] height,
                                 logic [31:0] shx, logic [31:0] shy);
        write_reg(REG_OVERLAY_COLOR, color);
        write_reg(REG_FRAME_WIDTH, width);
        write_reg(REG_FRAME_HEIGHT, height);
        write_reg(REG_CHROMA_SHIFT_X, shx);
        write_reg(REG_CHROMA_SHIFT_Y, shy);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // checked at the rising edge, where s_tvalid and the queues are settled
    task automatic wait_idle();
        while (pixel_q.size() != 0 || s_tvalid || blended_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic push_pixel(int cov, int x, int y, int oy, int ocb, int ocr);
        pix_word_t w;
        w.coverage = 8'(cov);
        w.pixel_x  = 12'(x);
        w.pixel_y  = 12'(y);
        w.old_luma = 8'(oy);
        w.old_cb   = 8'(ocb);
        w.old_cr   = 8'(ocr);
        pixel_q.push_back(w);
    endtask

    // mix of full range, frame edge and inside-frame positions
    function automatic int rand_coord(logic [DIM_W-1:0] lim);
        int v;
        int top;
        top = (lim > 4096) ? 4096 : int'(lim);
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 4095);
            1: v = int'(lim) - 2 + int'($urandom_range(0, 3));
            default: v = (top == 0) ? $urandom_range(0, 4095) : $urandom_range(0, top - 1);
        endcase
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v;
    endfunction

    function automatic int rand_byte();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic logic [31:0] rand_dim();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 1;
            2: return 4096;
            3: return 32'hFFFF_FFFF;
            4: return $urandom;
            default: return $urandom_range(1, 4096);
        endcase
    endfunction

    function automatic logic [31:0] rand_color();
        logic [31:0] c;
        c = $urandom;
        case ($urandom_range(0, 3))
            0: c[7:0] = 8'h00;
            1: c[7:0] = 8'hFF;
            default: ;
        endcase
        return c;
    endfunction

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: black, transparent-free, 1920 x 1080
        push_pixel(0, 0, 0, 0, 0, 0);
        push_pixel(255, 0, 0, 255, 255, 255);
        push_pixel(255, 1919, 1079, 8'hAA, 8'h55, 8'h80);
        push_pixel(255, 1920, 0, 10, 20, 30);
        push_pixel(128, 0, 1080, 10, 20, 30);
        push_pixel(255, 4095, 4095, 255, 0, 255);
        push_pixel(1, 1, 1, 1, 254, 128);
        wait_idle();

        // opaque white, full frame, no subsampling
        apply_setting(32'hFFFF_FF00, 4096, 4096, 0, 0);
        push_pixel(255, 4095, 4095, 0, 0, 0);
        push_pixel(255, 2048, 1, 255, 255, 255);
        push_pixel(0, 100, 200, 77, 88, 99);
        wait_idle();

        // fully transparent, one-pixel frame, shift of three
        apply_setting(32'h0000_00FF, 1, 1, 3, 3);
        push_pixel(255, 0, 0, 12, 34, 56);
        push_pixel(255, 1, 0, 12, 34, 56);
        push_pixel(255, 0, 1, 12, 34, 56);
        push_pixel(200, 4095, 4095, 12, 34, 56);
        wait_idle();

        // zero-size frame: nothing is written; stray write to an unused index
        apply_setting(32'hFF00_0000, 0, 0, 2, 1);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        push_pixel(255, 0, 0, 50, 60, 70);
        push_pixel(255, 4095, 0, 50, 60, 70);
        wait_idle();

        // red then green for negative chroma sums, widest masked frame
        apply_setting(32'hFF00_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3, 0);
        push_pixel(255, 4095, 4095, 0, 255, 0);
        wait_idle();
        apply_setting(32'h00FF_0080, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2, 3);
        push_pixel(255, 4095, 4095, 255, 0, 255);
        push_pixel(77, 3, 5, 128, 128, 128);
        wait_idle();

        for (int p = 0; p < 12; p++)
        begin
            apply_setting(rand_color(), rand_dim(), rand_dim(),
                          $urandom_range(0, 3), $urandom_range(0, 3));
            src_steady = (p % 4 == 1);
            sink_mode  = (p % 4 == 1) ? SINK_ALWAYS : sink_mode_t'($urandom_range(0, 2));
            sink_pat   = $urandom_range(1, 255);
            for (int i = 0; i < 120; i++)
                push_pixel(rand_byte(), rand_coord(cfg_width), rand_coord(cfg_height),
                           rand_byte(), rand_byte(), rand_byte());
            // long receiver hold-off so the pipeline fills and backs up the input
            if (p == 2 || p == 7)
                sink_hold_req = $urandom_range(40, 90);
            wait_idle();
        end

        repeat (12) @(posedge clk);
        if (mismatch_cnt == 0 && blended_q.size() == 0)
            $display("glyph_alpha_blend_yuv_top regression: pass");
        else
            $display("glyph_alpha_blend_yuv_top regression: fail");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("glyph_alpha_blend_yuv_top regression: fail");
        $finish;
    end

endmodule
